// File: rtl/core/awi_pkg.sv
// Shared constants, types and codes of the affine warp interpolator.
package awi_pkg;

    // Source store geometry and fixed-point format.
    localparam int MAX_ROWS  = 512;
    localparam int MAX_COLS  = 512;
    localparam int FRAC_BITS = 16;

    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int IDX_W   = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int BANK_AW = (ROW_W - 1) + (COL_W - 1);
    localparam int BANK_DEPTH = (MAX_ROWS / 2) * (MAX_COLS / 2);

    localparam int PIX_W  = 24;
    localparam int CHAN_W = 8;
    localparam int POS_W  = 12;
    localparam int SIZE_W = 10;
    localparam int COEF_W = 32;

    // Mapped position: product of a coefficient and a 13-bit signed position,
    // two products and an offset summed.
    localparam int PROD_W = COEF_W + POS_W + 1;
    localparam int VAL_W  = PROD_W + 2;
    localparam int INT_W  = VAL_W - FRAC_BITS;

    // Fractions below 0.01 count as zero: f * 100 < 2^FRAC_BITS.
    localparam int FRAC_MIN = ((1 << FRAC_BITS) + 99) / 100;

    // Blend weights and products.
    localparam int OMF_W   = FRAC_BITS + 1;
    localparam int WGT_W   = 2 * OMF_W;
    localparam int BPROD_W = WGT_W + CHAN_W;
    localparam int BLEND_W = BPROD_W + 2;

    // Configuration port.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        OP_LOAD     = 2'd0,
        OP_NEAREST  = 2'd1,
        OP_BILINEAR = 2'd2,
        OP_UNUSED   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_COEF_ROW_FROM_ROW = 3'd0,
        REG_COEF_ROW_FROM_COL = 3'd1,
        REG_OFFSET_ROW        = 3'd2,
        REG_COEF_COL_FROM_ROW = 3'd3,
        REG_COEF_COL_FROM_COL = 3'd4,
        REG_OFFSET_COL        = 3'd5,
        REG_SOURCE_ROWS       = 3'd6,
        REG_SOURCE_COLS       = 3'd7
    } reg_idx_t;

    // One mapped coordinate split into integer index and usable fraction.
    typedef struct packed {
        logic                 in_range;
        logic [IDX_W-1:0]     idx;
        logic [FRAC_BITS-1:0] frac;
    } split_t;

    // Truncate toward zero, test against the effective size, drop tiny fractions.
    function automatic split_t split_pos(logic signed [VAL_W-1:0] v, logic [SIZE_W-1:0] size);
        split_t            s;
        logic [INT_W-1:0]  ip;
        ip = v[VAL_W-1:FRAC_BITS];
        s.idx  = '0;
        s.frac = '0;
        if (v[VAL_W-1])
        begin
            // Values in (-1, 0) truncate to zero and count as inside a nonempty source.
            s.in_range = (&ip) && (|v[FRAC_BITS-1:0]) && (size != '0);
        end
        else
        begin
            s.in_range = ip < INT_W'(size);
            s.idx      = ip[IDX_W-1:0];
            if (v[FRAC_BITS-1:0] >= FRAC_BITS'(FRAC_MIN))
            begin
                s.frac = v[FRAC_BITS-1:0];
            end
        end
        return s;
    endfunction

    // Lower neighbour index: pulled down on the last line, zero for a single line.
    function automatic logic [IDX_W-1:0] low_neighbour(logic [IDX_W-1:0] idx,
                                                       logic [SIZE_W-1:0] size);
        logic [IDX_W-1:0] lo;
        if (size < SIZE_W'(2))
        begin
            lo = '0;
        end
        else if (SIZE_W'(idx) + SIZE_W'(1) >= size)
        begin
            lo = IDX_W'(size - SIZE_W'(2));
        end
        else
        begin
            lo = idx;
        end
        return lo;
    endfunction

endpackage

// File: rtl/core/affine_warp_interpolator.sv
// Affine warp with nearest or bilinear sampling from a banked source frame store.
//
// Usage: items enter on the s_ channel (s_tuser = operation, s_tdata = position and
// colour). A load item writes one pixel of the source frame and gives no result. A
// nearest or bilinear request maps the destination position through the affine matrix
// and gives one result on the m_ channel (m_tdata = colour, m_tuser = inside flag).
// Operation code 3 is dropped. The user must write the registers over the APB port only
// while idle; the block does not enforce this. Throughput: one item per cycle while the
// receiver takes results. The path has six register stages (products, sums, split and
// neighbours, store read and weights, blend products, output register). The store is four
// banks split by row and column parity, so the four bilinear neighbours are read together.
// Reset returns the registers to the identity mapping and a 512 by 512 source, and
// empties the pipeline; the store keeps no reset value and must be loaded before use.
// When the receiver stalls, the whole pipeline holds and s_tready falls; nothing is
// lost or repeated, and s_tready rises again as soon as the output is taken.
module affine_warp_interpolator
    import awi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // APB configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // Input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,   // pixel_row, pixel_col, in_red, in_green, in_blue
    input  logic [1:0]        s_tuser,   // operation
    // Output stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // out_red, out_green, out_blue
    output logic [0:0]        m_tuser    // inside_res
);

    // Configuration registers.
    logic signed [COEF_W-1:0] crr_reg, crc_reg, offr_reg, ccr_reg, ccc_reg, offc_reg;
    logic [SIZE_W-1:0]        rows_reg, cols_reg;
    logic                     cfg_wr;
    reg_idx_t                 cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crr_reg  <= COEF_W'(1 << FRAC_BITS);
            crc_reg  <= '0;
            offr_reg <= '0;
            ccr_reg  <= '0;
            ccc_reg  <= COEF_W'(1 << FRAC_BITS);
            offc_reg <= '0;
            rows_reg <= SIZE_W'(MAX_ROWS);
            cols_reg <= SIZE_W'(MAX_COLS);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_COEF_ROW_FROM_ROW: crr_reg  <= pwdata;
                REG_COEF_ROW_FROM_COL: crc_reg  <= pwdata;
                REG_OFFSET_ROW:        offr_reg <= pwdata;
                REG_COEF_COL_FROM_ROW: ccr_reg  <= pwdata;
                REG_COEF_COL_FROM_COL: ccc_reg  <= pwdata;
                REG_OFFSET_COL:        offc_reg <= pwdata;
                REG_SOURCE_ROWS:       rows_reg <= pwdata[SIZE_W-1:0];
                REG_SOURCE_COLS:       cols_reg <= pwdata[SIZE_W-1:0];
                default:               ;
            endcase
        end
    end

    // Register reads.
    always_comb
    begin
        case (cfg_idx)
            REG_COEF_ROW_FROM_ROW: prdata = crr_reg;
            REG_COEF_ROW_FROM_COL: prdata = crc_reg;
            REG_OFFSET_ROW:        prdata = offr_reg;
            REG_COEF_COL_FROM_ROW: prdata = ccr_reg;
            REG_COEF_COL_FROM_COL: prdata = ccc_reg;
            REG_OFFSET_COL:        prdata = offc_reg;
            REG_SOURCE_ROWS:       prdata = DATA_W'(rows_reg);
            REG_SOURCE_COLS:       prdata = DATA_W'(cols_reg);
            default:               prdata = '0;
        endcase
    end

    // Effective source size, saturated to the store.
    logic [SIZE_W-1:0] rows_eff, cols_eff;
    assign rows_eff = (rows_reg > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : rows_reg;
    assign cols_eff = (cols_reg > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : cols_reg;

    // Global advance: the pipeline moves whenever the output register can take data.
    logic adv;
    logic out_valid_reg;
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    // Input unpacking: the pixel is held with red in the top byte.
    op_t               in_op;
    logic [POS_W-1:0]  in_row, in_col;
    logic [PIX_W-1:0]  in_pix;
    assign in_op  = op_t'(s_tuser);
    assign in_row = s_tdata[11:0];
    assign in_col = s_tdata[23:12];
    assign in_pix = {s_tdata[31:24], s_tdata[39:32], s_tdata[47:40]};

    // Stage 1: the four matrix products.
    logic                      v1_reg;
    op_t                       op1_reg;
    logic [POS_W-1:0]          row1_reg, col1_reg;
    logic [PIX_W-1:0]          pix1_reg;
    logic signed [PROD_W-1:0]  prr_reg, prc_reg, pcr_reg, pcc_reg;
    logic signed [POS_W:0]     row_s, col_s;
    assign row_s = $signed({1'b0, in_row});
    assign col_s = $signed({1'b0, in_col});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg  <= in_op;
            row1_reg <= in_row;
            col1_reg <= in_col;
            pix1_reg <= in_pix;
            prr_reg  <= crr_reg * row_s;
            prc_reg  <= crc_reg * col_s;
            pcr_reg  <= ccr_reg * row_s;
            pcc_reg  <= ccc_reg * col_s;
        end
    end

    // Stage 2: sums give the mapped source row and column.
    logic                     v2_reg;
    op_t                      op2_reg;
    logic [POS_W-1:0]         row2_reg, col2_reg;
    logic [PIX_W-1:0]         pix2_reg;
    logic signed [VAL_W-1:0]  vr_reg, vc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op2_reg  <= op1_reg;
            row2_reg <= row1_reg;
            col2_reg <= col1_reg;
            pix2_reg <= pix1_reg;
            vr_reg   <= VAL_W'(prr_reg) + VAL_W'(prc_reg) + VAL_W'(offr_reg);
            vc_reg   <= VAL_W'(pcr_reg) + VAL_W'(pcc_reg) + VAL_W'(offc_reg);
        end
    end

    // Stage 3: split, range test and neighbour indices.
    split_t            sr, sc;
    logic [IDX_W-1:0]  r0, c0;
    assign sr = split_pos(vr_reg, rows_eff);
    assign sc = split_pos(vc_reg, cols_eff);
    assign r0 = (op2_reg == OP_BILINEAR) ? low_neighbour(sr.idx, rows_eff) : sr.idx;
    assign c0 = (op2_reg == OP_BILINEAR) ? low_neighbour(sc.idx, cols_eff) : sc.idx;

    logic                  v3_reg;
    op_t                   op3_reg;
    logic                  inside3_reg;
    logic [IDX_W-1:0]      r0_reg, r1_reg, c0_reg, c1_reg;
    logic [FRAC_BITS-1:0]  fr3_reg, fc3_reg;
    logic [POS_W-1:0]      row3_reg, col3_reg;
    logic [PIX_W-1:0]      pix3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op3_reg     <= op2_reg;
            inside3_reg <= sr.in_range && sc.in_range;
            r0_reg      <= r0;
            c0_reg      <= c0;
            // Second neighbour is the next line, or the same one for a single line or a nearest request.
            r1_reg      <= (op2_reg == OP_BILINEAR && rows_eff >= SIZE_W'(2)) ?
                           r0 + IDX_W'(1) : r0;
            c1_reg      <= (op2_reg == OP_BILINEAR && cols_eff >= SIZE_W'(2)) ?
                           c0 + IDX_W'(1) : c0;
            fr3_reg     <= sr.frac;
            fc3_reg     <= sc.frac;
            row3_reg    <= row2_reg;
            col3_reg    <= col2_reg;
            pix3_reg    <= pix2_reg;
        end
    end

    // Stage 4: store access (loads write, requests read) and blend weights.
    logic load_ok;
    assign load_ok = v3_reg && op3_reg == OP_LOAD &&
                     row3_reg < POS_W'(MAX_ROWS) && col3_reg < POS_W'(MAX_COLS);

    logic [PIX_W-1:0] bank_rd [4];

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [PIX_W-1:0]   mem [BANK_DEPTH];
        logic [PIX_W-1:0]   rd_reg;
        logic [IDX_W-1:0]   rsel, csel;
        logic [BANK_AW-1:0] raddr, waddr;
        logic               we;

        // Each bank holds one row parity and one column parity.
        assign rsel  = (r0_reg[0] == b[1]) ? r0_reg : r1_reg;
        assign csel  = (c0_reg[0] == b[0]) ? c0_reg : c1_reg;
        assign raddr = {rsel[ROW_W-1:1], csel[COL_W-1:1]};
        assign waddr = {row3_reg[ROW_W-1:1], col3_reg[COL_W-1:1]};
        assign we    = load_ok && row3_reg[0] == b[1] && col3_reg[0] == b[0];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (we)
                begin
                    mem[waddr] <= pix3_reg;
                end
                rd_reg <= mem[raddr];
            end
        end

        assign bank_rd[b] = rd_reg;
    end

    logic [OMF_W-1:0] omfr, omfc;
    assign omfr = OMF_W'(1 << FRAC_BITS) - OMF_W'(fr3_reg);
    assign omfc = OMF_W'(1 << FRAC_BITS) - OMF_W'(fc3_reg);

    logic              v4_reg;
    op_t               op4_reg;
    logic              inside4_reg;
    logic [1:0]        sa4_reg, sb4_reg, sc4_reg, sd4_reg;
    logic [WGT_W-1:0]  wa_reg, wb_reg, wc_reg, wd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op4_reg     <= op3_reg;
            inside4_reg <= inside3_reg;
            sa4_reg     <= {r0_reg[0], c0_reg[0]};
            sb4_reg     <= {r0_reg[0], c1_reg[0]};
            sc4_reg     <= {r1_reg[0], c0_reg[0]};
            sd4_reg     <= {r1_reg[0], c1_reg[0]};
            wa_reg      <= omfr * omfc;
            wb_reg      <= omfr * OMF_W'(fc3_reg);
            wc_reg      <= OMF_W'(fr3_reg) * omfc;
            wd_reg      <= OMF_W'(fr3_reg) * OMF_W'(fc3_reg);
        end
    end

    // Stage 5: pick the four neighbours from the banks and form weighted products.
    logic [PIX_W-1:0] pa, pb, pc, pd;
    assign pa = bank_rd[sa4_reg];
    assign pb = bank_rd[sb4_reg];
    assign pc = bank_rd[sc4_reg];
    assign pd = bank_rd[sd4_reg];

    logic               v5_reg;
    op_t                op5_reg;
    logic               inside5_reg;
    logic [PIX_W-1:0]   near5_reg;
    logic [BPROD_W-1:0] bp_reg [3][4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op5_reg     <= op4_reg;
            inside5_reg <= inside4_reg;
            near5_reg   <= pa;
            for (int k = 0; k < 3; k++)
            begin
                bp_reg[k][0] <= wa_reg * pa[PIX_W-1-CHAN_W*k -: CHAN_W];
                bp_reg[k][1] <= wb_reg * pb[PIX_W-1-CHAN_W*k -: CHAN_W];
                bp_reg[k][2] <= wc_reg * pc[PIX_W-1-CHAN_W*k -: CHAN_W];
                bp_reg[k][3] <= wd_reg * pd[PIX_W-1-CHAN_W*k -: CHAN_W];
            end
        end
    end

    // Stage 6: sum, truncate and choose the result; requests only reach the output.
    logic [PIX_W-1:0]   blend_pix;
    logic [PIX_W-1:0]   out_pix_next;
    logic               is_req5;
    logic [BLEND_W-1:0] bsum [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            bsum[k] = BLEND_W'(bp_reg[k][0]) + BLEND_W'(bp_reg[k][1]) +
                      BLEND_W'(bp_reg[k][2]) + BLEND_W'(bp_reg[k][3]);
            blend_pix[PIX_W-1-CHAN_W*k -: CHAN_W] = bsum[k][2*FRAC_BITS +: CHAN_W];
        end
    end

    assign is_req5 = op5_reg == OP_NEAREST || op5_reg == OP_BILINEAR;

    always_comb
    begin
        if (!inside5_reg)
        begin
            out_pix_next = '0;
        end
        else if (op5_reg == OP_NEAREST)
        begin
            out_pix_next = near5_reg;
        end
        else
        begin
            out_pix_next = blend_pix;
        end
    end

    logic [PIX_W-1:0] out_pix_reg;
    logic             out_inside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= v5_reg && is_req5;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_pix_reg    <= out_pix_next;
            out_inside_reg <= inside5_reg;
        end
    end

    // Output packing: red in the low byte.
    assign m_tvalid          = out_valid_reg;
    assign m_tdata[7:0]      = out_pix_reg[23:16];
    assign m_tdata[15:8]     = out_pix_reg[15:8];
    assign m_tdata[23:16]    = out_pix_reg[7:0];
    assign m_tuser[0]        = out_inside_reg;

`ifndef SYNTH
    // Input is held back only by a stalled, full output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without an output stall");

    // A position outside the source always carries zero colour.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("outside result with nonzero colour");

    // Loads and unused codes never produce a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && v5_reg && !is_req5) |=> !m_tvalid)
        else $error("result produced by a non-request item");

    // A store write happens only for a load in stage three.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_ok |-> (v3_reg && op3_reg == OP_LOAD))
        else $error("store write without a load");
`endif

endmodule
